>>> design/vfc_pkg.sv
`default_nettype none

package vfc_pkg;

    localparam int CHUNK_EDGE_DEF    = 16;
    localparam int COLUMN_HEIGHT_DEF = 256;

    localparam int IN_TDATA_W  = 48;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 144;

    localparam int CFG_W     = 21;
    localparam int CFG_IDX_W = 1;
    localparam int WORLD_W   = 25;
    localparam int VTX_W     = 32;

    // working widths of a neighbor coordinate (input plus a one-cell step)
    localparam int XZ_W = 8;
    localparam int Y_W  = 12;

    localparam int QUEUE_DEPTH = 2;
    localparam int FACES       = 6;
    localparam int STEP_W      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_COL_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_COL_Z = 1'b1;

    localparam logic [STEP_W-1:0] FACE_POS_Y = 3'd0;
    localparam logic [STEP_W-1:0] FACE_NEG_Y = 3'd1;
    localparam logic [STEP_W-1:0] FACE_POS_X = 3'd2;
    localparam logic [STEP_W-1:0] FACE_NEG_X = 3'd3;
    localparam logic [STEP_W-1:0] FACE_POS_Z = 3'd4;
    localparam logic [STEP_W-1:0] FACE_NEG_Z = 3'd5;
    localparam logic [STEP_W-1:0] FACE_SELF  = 3'd6;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_MESH  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        K_LOAD,
        K_MESH,
        K_CLEAR
    } t_kind;

    typedef enum logic [2:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_LD_RD,
        BS_LD_WR,
        BS_MS_RD,
        BS_MS_EMIT
    } t_bstate;

    // last field in the lowest bits
    typedef struct packed {
        logic [2:0]        pad;
        logic [7:0]        blue_in;
        logic [7:0]        green_in;
        logic [7:0]        red_in;
        logic              is_solid;
        logic signed [5:0] local_z;
        logic [7:0]        cell_y;
        logic signed [5:0] local_x;
    } t_in_data;

    typedef struct packed {
        logic [2:0]                pad;
        logic [VTX_W-1:0]          vertex_base;
        logic [15:0]               shade_blue;
        logic [15:0]               shade_green;
        logic [15:0]               shade_red;
        logic signed [WORLD_W-1:0] world_z;
        logic [7:0]                world_y;
        logic signed [WORLD_W-1:0] world_x;
        logic [2:0]                face_dir;
    } t_result;

    typedef struct packed {
        t_kind             kind;
        logic signed [5:0] x;
        logic [7:0]        y;
        logic signed [5:0] z;
        logic              solid;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic clearing;
        logic idle;
    } t_back_stat;

    typedef struct packed {
        logic signed [1:0] dx;
        logic signed [1:0] dy;
        logic signed [1:0] dz;
    } t_offset;

    function automatic t_offset face_offset(input logic [STEP_W-1:0] f);
        t_offset o;
        o = '0;
        unique case (f)
            FACE_POS_Y: o.dy = 2'sd1;
            FACE_NEG_Y: o.dy = -2'sd1;
            FACE_POS_X: o.dx = 2'sd1;
            FACE_NEG_X: o.dx = -2'sd1;
            FACE_POS_Z: o.dz = 2'sd1;
            FACE_NEG_Z: o.dz = -2'sd1;
            default:    o = '0;
        endcase
        return o;
    endfunction

    // face shading in 1/256 units
    function automatic logic [8:0] face_factor(input logic [STEP_W-1:0] f);
        logic [8:0] k;
        unique case (f)
            FACE_POS_Y: k = 9'd256;
            FACE_NEG_Y: k = 9'd102;
            FACE_POS_X: k = 9'd179;
            FACE_NEG_X: k = 9'd179;
            FACE_POS_Z: k = 9'd218;
            FACE_NEG_Z: k = 9'd218;
            default:    k = 9'd0;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

>>> design/vfc_front.sv
`default_nettype none

module vfc_front #(
    parameter int CHUNK_EDGE    = vfc_pkg::CHUNK_EDGE_DEF,
    parameter int COLUMN_HEIGHT = vfc_pkg::COLUMN_HEIGHT_DEF
) (
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [vfc_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic [vfc_pkg::IN_TUSER_W-1:0]  i_s_tuser,
    input  vfc_pkg::t_q_stat                i_q_stat,
    input  vfc_pkg::t_back_stat             i_back_stat,
    output logic                            o_push,
    output vfc_pkg::t_entry                 o_entry
);

    vfc_pkg::t_in_data w_in;
    logic              w_load_ok;
    logic              w_keep;
    vfc_pkg::t_kind    w_kind;

    assign w_in = i_s_tdata;

    assign w_load_ok = (w_in.local_x >= -1) && (w_in.local_x <= CHUNK_EDGE) &&
                       (w_in.local_z >= -1) && (w_in.local_z <= CHUNK_EDGE) &&
                       (int'(w_in.cell_y) < COLUMN_HEIGHT);

    // drop loads outside the store, empty mesh voxels and unused commands
    always_comb begin
        w_keep = 1'b0;
        w_kind = vfc_pkg::K_LOAD;
        unique case (i_s_tuser)
            vfc_pkg::CMD_LOAD: begin
                w_keep = w_load_ok;
                w_kind = vfc_pkg::K_LOAD;
            end
            vfc_pkg::CMD_MESH: begin
                w_keep = w_in.is_solid;
                w_kind = vfc_pkg::K_MESH;
            end
            vfc_pkg::CMD_CLEAR: begin
                w_keep = 1'b1;
                w_kind = vfc_pkg::K_CLEAR;
            end
            default: begin
                w_keep = 1'b0;
                w_kind = vfc_pkg::K_LOAD;
            end
        endcase
    end

    assign o_s_tready = !i_q_stat.full && !i_back_stat.clearing;
    assign o_push     = i_s_tvalid && o_s_tready && w_keep;

    assign o_entry.kind  = w_kind;
    assign o_entry.x     = w_in.local_x;
    assign o_entry.y     = w_in.cell_y;
    assign o_entry.z     = w_in.local_z;
    assign o_entry.solid = w_in.is_solid;
    assign o_entry.red   = w_in.red_in;
    assign o_entry.green = w_in.green_in;
    assign o_entry.blue  = w_in.blue_in;

endmodule

`default_nettype wire

>>> design/vfc_queue.sv
`default_nettype none

module vfc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  vfc_pkg::t_entry  i_entry,
    input  logic             i_pop,
    output vfc_pkg::t_entry  o_entry,
    output vfc_pkg::t_q_stat o_stat
);

    localparam int PTR_W = (vfc_pkg::QUEUE_DEPTH > 1) ? $clog2(vfc_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(vfc_pkg::QUEUE_DEPTH + 1);

    vfc_pkg::t_entry  r_slot [vfc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_stat.full  = (r_count == CNT_W'(vfc_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_entry      = r_slot[r_rd_ptr];

    assign w_do_push = i_push && !o_stat.full;
    assign w_do_pop  = i_pop && !o_stat.empty;

    assign n_wr_ptr = (r_wr_ptr == PTR_W'(vfc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(vfc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (w_do_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

>>> design/vfc_back.sv
`default_nettype none

module vfc_back #(
    parameter int CHUNK_EDGE    = vfc_pkg::CHUNK_EDGE_DEF,
    parameter int COLUMN_HEIGHT = vfc_pkg::COLUMN_HEIGHT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [vfc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [vfc_pkg::CFG_W-1:0]        i_cfg_data,
    input  vfc_pkg::t_q_stat                 i_q_stat,
    input  vfc_pkg::t_entry                  i_entry,
    output logic                             o_pop,
    output vfc_pkg::t_back_stat              o_stat,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [vfc_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    output logic                             o_m_tlast
);

    localparam int RING  = CHUNK_EDGE + 2;
    localparam int DEPTH = RING * COLUMN_HEIGHT;
    localparam int ROW_W = $clog2(DEPTH);
    localparam int BIT_W = $clog2(RING);
    localparam int FACES = vfc_pkg::FACES;
    localparam int STEP_W = vfc_pkg::STEP_W;
    localparam int XZ_W  = vfc_pkg::XZ_W;
    localparam int Y_W   = vfc_pkg::Y_W;
    localparam int WORLD_W = vfc_pkg::WORLD_W;

    // occupancy store: one row holds all x cells of one (y, z) pair
    logic [RING-1:0] r_store [DEPTH];
    logic [RING-1:0] r_rdata;

    vfc_pkg::t_bstate          r_state;
    vfc_pkg::t_bstate          n_state;
    logic [STEP_W-1:0]         r_step;
    logic [FACES-1:0]          r_mask;
    logic [ROW_W-1:0]          r_clr_row;
    vfc_pkg::t_entry           r_ent;
    logic                      r_rd_inr;
    logic [BIT_W-1:0]          r_rd_bit;
    logic [vfc_pkg::VTX_W-1:0] r_vtx;
    logic signed [WORLD_W-1:0] r_org_x;
    logic signed [WORLD_W-1:0] r_org_z;
    vfc_pkg::t_result          r_out;
    logic                      r_out_vld;
    logic                      r_out_last;

    logic [STEP_W-1:0]       w_sel;
    vfc_pkg::t_offset        w_off;
    logic signed [XZ_W-1:0]  w_nx;
    logic signed [XZ_W-1:0]  w_nz;
    logic signed [Y_W-1:0]   w_ny;
    logic                    w_inr;
    logic [ROW_W-1:0]        w_row;
    logic [BIT_W-1:0]        w_bit;
    logic [RING-1:0]         w_ld_row;
    logic                    w_empty_bit;
    logic [STEP_W-1:0]       w_pick;
    logic [FACES-1:0]        w_low_oh;
    logic [FACES-1:0]        w_rest;
    logic                    w_out_free;
    logic [8:0]              w_factor;

    logic                    w_mem_re;
    logic                    w_mem_we;
    logic [ROW_W-1:0]        w_mem_addr;
    logic [RING-1:0]         w_mem_wdata;
    logic                    w_emit;

    // neighbor address
    assign w_sel = (r_state == vfc_pkg::BS_LD_RD || r_state == vfc_pkg::BS_LD_WR) ?
                   vfc_pkg::FACE_SELF : r_step;
    assign w_off = vfc_pkg::face_offset(w_sel);
    assign w_nx  = XZ_W'(r_ent.x) + XZ_W'(w_off.dx);
    assign w_nz  = XZ_W'(r_ent.z) + XZ_W'(w_off.dz);
    assign w_ny  = Y_W'($signed({1'b0, r_ent.y})) + Y_W'(w_off.dy);

    assign w_inr = (w_nx >= -1) && (w_nx <= CHUNK_EDGE) &&
                   (w_nz >= -1) && (w_nz <= CHUNK_EDGE) &&
                   (w_ny >= 0)  && (w_ny < COLUMN_HEIGHT);

    assign w_row = ROW_W'(int'(w_ny) * RING + int'(w_nz) + 1);
    assign w_bit = BIT_W'(int'(w_nx) + 1);

    always_comb begin
        w_ld_row        = r_rdata;
        w_ld_row[w_bit] = r_ent.solid;
    end

    // cells outside the store read as empty
    assign w_empty_bit = !(r_rd_inr && r_rdata[r_rd_bit]);

    // lowest pending face
    always_comb begin
        w_pick = vfc_pkg::FACE_POS_Y;
        for (int i = FACES - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                w_pick = STEP_W'(i);
            end
        end
    end

    always_comb begin
        w_low_oh         = '0;
        w_low_oh[w_pick] = 1'b1;
    end

    assign w_rest     = r_mask & ~w_low_oh;
    assign w_out_free = !r_out_vld || i_m_tready;
    assign w_factor   = vfc_pkg::face_factor(w_pick);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vfc_pkg::BS_CLEAR: begin
                if (r_clr_row == ROW_W'(DEPTH - 1)) begin
                    n_state = vfc_pkg::BS_IDLE;
                end
            end
            vfc_pkg::BS_IDLE: begin
                if (!i_q_stat.empty) begin
                    unique case (i_entry.kind)
                        vfc_pkg::K_LOAD:  n_state = vfc_pkg::BS_LD_RD;
                        vfc_pkg::K_MESH:  n_state = vfc_pkg::BS_MS_RD;
                        vfc_pkg::K_CLEAR: n_state = vfc_pkg::BS_CLEAR;
                        default:          n_state = vfc_pkg::BS_IDLE;
                    endcase
                end
            end
            vfc_pkg::BS_LD_RD: n_state = vfc_pkg::BS_LD_WR;
            vfc_pkg::BS_LD_WR: n_state = vfc_pkg::BS_IDLE;
            vfc_pkg::BS_MS_RD: begin
                if (r_step == STEP_W'(FACES)) begin
                    n_state = vfc_pkg::BS_MS_EMIT;
                end
            end
            vfc_pkg::BS_MS_EMIT: begin
                if (r_mask == '0) begin
                    n_state = vfc_pkg::BS_IDLE;
                end else if (w_out_free && w_rest == '0) begin
                    n_state = vfc_pkg::BS_IDLE;
                end
            end
            default: n_state = vfc_pkg::BS_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_mem_re    = 1'b0;
        w_mem_we    = 1'b0;
        w_mem_addr  = w_row;
        w_mem_wdata = w_ld_row;
        o_pop       = 1'b0;
        w_emit      = 1'b0;
        unique case (r_state)
            vfc_pkg::BS_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_addr  = r_clr_row;
                w_mem_wdata = '0;
            end
            vfc_pkg::BS_IDLE:    o_pop    = !i_q_stat.empty;
            vfc_pkg::BS_LD_RD:   w_mem_re = 1'b1;
            vfc_pkg::BS_LD_WR:   w_mem_we = 1'b1;
            vfc_pkg::BS_MS_RD:   w_mem_re = (r_step < STEP_W'(FACES)) && w_inr;
            vfc_pkg::BS_MS_EMIT: w_emit   = (r_mask != '0) && w_out_free;
            default: ;
        endcase
    end

    assign o_stat.clearing = (r_state == vfc_pkg::BS_CLEAR);
    assign o_stat.idle     = (r_state == vfc_pkg::BS_IDLE);

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_store[w_mem_addr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_rdata <= r_store[w_mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= vfc_pkg::BS_CLEAR;
            r_clr_row <= '0;
            r_step    <= '0;
            r_vtx     <= '0;
            r_org_x   <= '0;
            r_org_z   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == vfc_pkg::BS_CLEAR) begin
                r_clr_row <= r_clr_row + 1'b1;
            end
            if (o_pop) begin
                r_step <= '0;
                if (i_entry.kind == vfc_pkg::K_CLEAR) begin
                    r_vtx     <= '0;
                    r_clr_row <= '0;
                end
            end
            if (r_state == vfc_pkg::BS_MS_RD) begin
                r_step <= r_step + 1'b1;
            end
            if (w_emit) begin
                r_vtx     <= r_vtx + 32'd4;
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    vfc_pkg::CFG_CHUNK_COL_X:
                        r_org_x <= WORLD_W'($signed(i_cfg_data) * CHUNK_EDGE);
                    vfc_pkg::CFG_CHUNK_COL_Z:
                        r_org_z <= WORLD_W'($signed(i_cfg_data) * CHUNK_EDGE);
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_entry;
        end
        if (r_state == vfc_pkg::BS_MS_RD) begin
            // shift in the result of the read issued at the previous step
            if (r_step != '0) begin
                r_mask <= {w_empty_bit, r_mask[FACES-1:1]};
            end
            r_rd_inr <= w_inr;
            r_rd_bit <= w_bit;
        end
        if (w_emit) begin
            r_mask              <= w_rest;
            r_out.pad           <= '0;
            r_out.face_dir      <= w_pick;
            r_out.world_x       <= r_org_x + WORLD_W'(r_ent.x);
            r_out.world_y       <= r_ent.y;
            r_out.world_z       <= r_org_z + WORLD_W'(r_ent.z);
            r_out.shade_red     <= 16'(r_ent.red) * 16'(w_factor);
            r_out.shade_green   <= 16'(r_ent.green) * 16'(w_factor);
            r_out.shade_blue    <= 16'(r_ent.blue) * 16'(w_factor);
            r_out.vertex_base   <= r_vtx;
            r_out_last          <= (w_rest == '0);
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

>>> design/voxel_face_cull_mesher_unit.sv
// Channel   Dir  Handshake              Payload
// s         in   i_s_tvalid/o_s_tready  tuser: cmd; tdata: local_x, cell_y, local_z,
//                                       is_solid, red_in, green_in, blue_in
// m         out  o_m_tvalid/i_m_tready  tdata: face_dir, world_x, world_y, world_z,
//                                       shade_red/green/blue, vertex_base; tlast: last
// cfg       in   i_cfg_we               i_cfg_idx, i_cfg_data
//
// A mesh voxel goes through the back end as a dequeue, six neighbor reads and one capture
// through the single occupancy port, then an emit step per face, at least one step, each
// waiting for a free output register. A load is a dequeue, a read and a write back. Dropped
// items cost no back-end time. A clear is a dequeue, then a sweep of all the
// (CHUNK_EDGE+2)*COLUMN_HEIGHT store rows, one store row a cycle; after reset the same sweep runs with o_s_tready low.
// A two-entry queue sits between front and back; faces wait in an output register.
`default_nettype none

module voxel_face_cull_mesher_unit #(
    parameter int CHUNK_EDGE    = vfc_pkg::CHUNK_EDGE_DEF,
    parameter int COLUMN_HEIGHT = vfc_pkg::COLUMN_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // local_x[5:0], cell_y[13:6], local_z[19:14], is_solid[20], red_in[28:21],
    // green_in[36:29], blue_in[44:37], zero pad
    input  logic [vfc_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // cmd[1:0]
    input  logic [vfc_pkg::IN_TUSER_W-1:0]  i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // face_dir[2:0], world_x[27:3], world_y[35:28], world_z[60:36], shade_red[76:61],
    // shade_green[92:77], shade_blue[108:93], vertex_base[140:109], zero pad
    output logic [vfc_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    output logic                            o_m_tlast,
    input  logic                            i_cfg_we,
    input  logic [vfc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [vfc_pkg::CFG_W-1:0]       i_cfg_data
);

    vfc_pkg::t_q_stat    w_q_stat;
    vfc_pkg::t_back_stat w_back_stat;
    vfc_pkg::t_entry     w_push_entry;
    vfc_pkg::t_entry     w_head_entry;
    logic                w_push;
    logic                w_pop;

    vfc_front #(
        .CHUNK_EDGE    (CHUNK_EDGE),
        .COLUMN_HEIGHT (COLUMN_HEIGHT)
    ) u_front (
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_q_stat    (w_q_stat),
        .i_back_stat (w_back_stat),
        .o_push      (w_push),
        .o_entry     (w_push_entry)
    );

    vfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_entry (w_head_entry),
        .o_stat  (w_q_stat)
    );

    vfc_back #(
        .CHUNK_EDGE    (CHUNK_EDGE),
        .COLUMN_HEIGHT (COLUMN_HEIGHT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_stat   (w_q_stat),
        .i_entry    (w_head_entry),
        .o_pop      (w_pop),
        .o_stat     (w_back_stat),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire

>>> design/vfc_checker.sv
`default_nettype none

module vfc_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            o_s_tready,
    input wire logic                            o_m_tvalid,
    input wire logic                            i_m_tready,
    input wire logic [vfc_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input wire logic                            o_m_tlast
);

    vfc_pkg::t_result          w_res;
    logic                      w_xfer;
    logic                      r_open;
    logic [vfc_pkg::VTX_W-1:0] r_prev_vb;
    logic [2:0]                r_prev_face;

    assign w_res  = o_m_tdata;
    assign w_xfer = o_m_tvalid && i_m_tready;

    // track the previous face of a voxel whose run has not ended
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
        end else if (w_xfer) begin
            r_open <= !o_m_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_xfer) begin
            r_prev_vb   <= w_res.vertex_base;
            r_prev_face <= w_res.face_dir;
        end
    end

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && !o_s_tready)
        else $error("outputs active right after reset");

    a_face_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> w_res.face_dir <= vfc_pkg::FACE_NEG_Z)
        else $error("face direction out of range");

    a_run_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_xfer && r_open |->
            (w_res.vertex_base == r_prev_vb + 32'd4) && (w_res.face_dir > r_prev_face))
        else $error("faces of one voxel out of order or vertex base skipped");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled result transaction changed");

endmodule

bind voxel_face_cull_mesher_unit vfc_checker u_vfc_checker (.*);

`default_nettype wire

>>> sim/voxel_face_cull_mesher_unit_tb.sv
`default_nettype none

module voxel_face_cull_mesher_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vfc_pkg::*;

    localparam int EDGE         = CHUNK_EDGE_DEF;
    localparam int HEIGHT       = COLUMN_HEIGHT_DEF;
    localparam int RING         = EDGE + 2;
    localparam int STORE_CELLS  = RING * RING * HEIGHT;
    localparam int MAX_WAIT     = 18;
    localparam int LONG_HOLD    = 300;
    localparam int ITEM_SETTLE  = 40;
    localparam int CLEAR_SETTLE = 1 + RING * HEIGHT + 100;
    localparam int RANDOM_ITEMS = 300;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic signed [CFG_W-1:0] COL_MIN = {1'b1, {(CFG_W - 1){1'b0}}};
    localparam logic signed [CFG_W-1:0] COL_MAX = {1'b0, {(CFG_W - 1){1'b1}}};

    typedef struct packed {
        logic    last;
        t_result face;
    } face_exp_t;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;
    logic [IN_TUSER_W-1:0]  i_s_tuser  = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tlast;
    logic                   i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx  = '0;
    logic [CFG_W-1:0]       i_cfg_data = '0;

    // mirror of the block's state
    bit                       cell_solid_map [STORE_CELLS];
    logic [VTX_W-1:0]         vertex_count_model = '0;
    logic signed [CFG_W-1:0]  col_x_model = '0;
    logic signed [CFG_W-1:0]  col_z_model = '0;

    face_exp_t pending_faces[$];
    int        mismatches    = 0;
    int        applied_items = 0;
    bit        clear_pending = 1'b0;
    bit        calm          = 1'b0;
    bit        hold_req      = 1'b0;

    voxel_face_cull_mesher_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic bit cell_in_store(input int x, input int y, input int z);
        return x >= -1 && x <= EDGE && z >= -1 && z <= EDGE && y >= 0 && y < HEIGHT;
    endfunction

    function automatic int cell_addr(input int x, input int y, input int z);
        return (y * RING + z + 1) * RING + x + 1;
    endfunction

    // cells outside the store always read empty
    function automatic bit neighbor_solid(input int x, input int y, input int z);
        if (!cell_in_store(x, y, z))
            return 1'b0;
        return cell_solid_map[cell_addr(x, y, z)];
    endfunction

    function automatic void face_geometry(input logic [STEP_W-1:0] dir,
                                          output int dx, output int dy, output int dz,
                                          output int shade);
        dx = 0;
        dy = 0;
        dz = 0;
        shade = 0;
        case (dir)
            FACE_POS_Y: begin dy = 1;  shade = 256; end
            FACE_NEG_Y: begin dy = -1; shade = 102; end
            FACE_POS_X: begin dx = 1;  shade = 179; end
            FACE_NEG_X: begin dx = -1; shade = 179; end
            FACE_POS_Z: begin dz = 1;  shade = 218; end
            FACE_NEG_Z: begin dz = -1; shade = 218; end
            default: ;
        endcase
    endfunction

    function automatic t_in_data voxel(input int x, input int y, input int z,
                                       input bit solid, input logic [23:0] rgb);
        t_in_data v;
        v = '0;
        v.local_x  = 6'(x);
        v.cell_y   = 8'(y);
        v.local_z  = 6'(z);
        v.is_solid = solid;
        v.red_in   = rgb[7:0];
        v.green_in = rgb[15:8];
        v.blue_in  = rgb[23:16];
        return v;
    endfunction

    function automatic t_in_data random_fields();
        return voxel(int'($urandom_range(0, 63)) - 32, int'($urandom_range(0, 255)),
                     int'($urandom_range(0, 63)) - 32, $urandom_range(0, 1) != 0,
                     24'($urandom()));
    endfunction

    function automatic int draw_wait();
        if (calm)
            return 0;
        if ($urandom_range(0, 2) == 0)
            return 0;
        return int'($urandom_range(0, MAX_WAIT));
    endfunction

    // update the mirrored store and queue the faces one accepted item produces
    task automatic predict_faces(input logic [1:0] cmd, input t_in_data d);
        int        x, y, z, dx, dy, dz, shade, wx, wz, k;
        bit [5:0]  open;
        face_exp_t f;
        x = int'($signed(d.local_x));
        y = int'(d.cell_y);
        z = int'($signed(d.local_z));
        case (cmd)
            CMD_LOAD: begin
                if (cell_in_store(x, y, z)) begin
                    cell_solid_map[cell_addr(x, y, z)] = d.is_solid;
                    applied_items++;
                end
            end
            CMD_CLEAR: begin
                foreach (cell_solid_map[i])
                    cell_solid_map[i] = 1'b0;
                vertex_count_model = '0;
                clear_pending = 1'b1;
                applied_items++;
            end
            CMD_MESH: begin
                applied_items++;
                if (d.is_solid) begin
                    wx = int'(col_x_model) * EDGE + x;
                    wz = int'(col_z_model) * EDGE + z;
                    open = '0;
                    for (k = 0; k < FACES; k++) begin
                        face_geometry(STEP_W'(k), dx, dy, dz, shade);
                        open[k] = !neighbor_solid(x + dx, y + dy, z + dz);
                    end
                    for (k = 0; k < FACES; k++) begin
                        if (open[k]) begin
                            face_geometry(STEP_W'(k), dx, dy, dz, shade);
                            f = '0;
                            f.face.face_dir    = STEP_W'(k);
                            f.face.world_x     = wx[WORLD_W-1:0];
                            f.face.world_y     = d.cell_y;
                            f.face.world_z     = wz[WORLD_W-1:0];
                            f.face.shade_red   = 16'(d.red_in * shade);
                            f.face.shade_green = 16'(d.green_in * shade);
                            f.face.shade_blue  = 16'(d.blue_in * shade);
                            f.face.vertex_base = vertex_count_model;
                            f.last             = (open >> (k + 1)) == '0;
                            vertex_count_model += VTX_W'(4);
                            pending_faces.push_back(f);
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_item(input logic [1:0] cmd, input t_in_data d);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        i_s_tuser  <= cmd;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_faces(cmd, d);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic signed [CFG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_CHUNK_COL_X)
            col_x_model = value;
        else
            col_z_model = value;
    endtask

    // hold until every face is out, then give any silent work time to finish
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (pending_faces.size() != 0) @(posedge i_clk);
        repeat (clear_pending ? CLEAR_SETTLE : ITEM_SETTLE) @(posedge i_clk);
        clear_pending = 1'b0;
    endtask

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic check_face(input t_result got, input logic got_last);
        face_exp_t want;
        if (pending_faces.size() == 0) begin
            $error("face with nothing pending: face_dir %0d vertex_base %0d",
                   got.face_dir, got.vertex_base);
            mismatches++;
            return;
        end
        want = pending_faces.pop_front();
        check_field("face_dir", want.face.face_dir, got.face_dir);
        check_field("world_x", want.face.world_x, got.world_x);
        check_field("world_y", want.face.world_y, got.world_y);
        check_field("world_z", want.face.world_z, got.world_z);
        check_field("shade_red", want.face.shade_red, got.shade_red);
        check_field("shade_green", want.face.shade_green, got.shade_green);
        check_field("shade_blue", want.face.shade_blue, got.shade_blue);
        check_field("vertex_base", want.face.vertex_base, got.vertex_base);
        check_field("last", want.last, got_last);
    endtask

    // face receiver: random stalls, plus one long hold-off on request
    initial begin : face_sink
        int stall;
        wait (i_rst_n);
        forever begin
            if (hold_req) begin
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
            end
            stall = draw_wait();
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
            check_face(o_m_tdata, o_m_tlast);
        end
    end

    task automatic test_directed_faces();
        int k, dx, dy, dz, shade;
        // exposed voxel at the bottom of the column, full and zero colour
        send_item(CMD_MESH, voxel(0, 0, 0, 1'b1, 24'hFFFFFF));
        send_item(CMD_MESH, voxel(0, 0, 0, 1'b1, 24'h000000));
        send_item(CMD_MESH, voxel(3, 10, 3, 1'b0, 24'($urandom())));
        // wall in a voxel on all sides, then open its floor
        for (k = 0; k < FACES; k++) begin
            face_geometry(STEP_W'(k), dx, dy, dz, shade);
            send_item(CMD_LOAD, voxel(8 + dx, 128 + dy, 8 + dz, 1'b1, 24'($urandom())));
        end
        send_item(CMD_MESH, voxel(8, 128, 8, 1'b1, 24'($urandom())));
        send_item(CMD_LOAD, voxel(8, 127, 8, 1'b0, 24'($urandom())));
        send_item(CMD_MESH, voxel(8, 128, 8, 1'b1, 24'($urandom())));
        // a load past the ring is dropped, so the ring cell stays exposed
        send_item(CMD_LOAD, voxel(EDGE + 1, 5, 5, 1'b1, 24'($urandom())));
        send_item(CMD_MESH, voxel(EDGE, 5, 5, 1'b1, 24'($urandom())));
        send_item(CMD_LOAD, voxel(-1, 0, EDGE, 1'b1, 24'($urandom())));
        send_item(CMD_MESH, voxel(0, 0, EDGE, 1'b1, 24'($urandom())));
        send_item(CMD_MESH, voxel(-1, HEIGHT - 1, -1, 1'b1, 24'($urandom())));
        send_item(CMD_MESH, voxel(-32, 0, 31, 1'b1, 24'($urandom())));
        send_item(CMD_MESH, voxel(31, 7, -32, 1'b1, 24'($urandom())));
        send_item(CMD_UNUSED, random_fields());
        send_item(CMD_LOAD, voxel(2, 200, 2, 1'b1, 24'($urandom())));
        send_item(CMD_LOAD, voxel(2, 201, 2, 1'b1, 24'($urandom())));
        send_item(CMD_MESH, voxel(2, 200, 2, 1'b1, 24'($urandom())));
        // clear wipes the store and restarts vertex numbering
        send_item(CMD_CLEAR, random_fields());
        send_item(CMD_MESH, voxel(8, 128, 8, 1'b1, 24'($urandom())));
    endtask

    task automatic test_world_extremes();
        int s;
        for (s = 0; s < 2; s++) begin
            wait_idle();
            write_reg(CFG_CHUNK_COL_X, (s == 0) ? COL_MIN : COL_MAX);
            write_reg(CFG_CHUNK_COL_Z, (s == 0) ? COL_MAX : COL_MIN);
            send_item(CMD_MESH, voxel(-1, 1, EDGE, 1'b1, 24'($urandom())));
            send_item(CMD_MESH, voxel(EDGE, 2, -1, 1'b1, 24'($urandom())));
            send_item(CMD_MESH, voxel(-32, 3, 31, 1'b1, 24'($urandom())));
            send_item(CMD_MESH, voxel(31, 4, -32, 1'b1, 24'($urandom())));
        end
    endtask

    // keep offering voxels while the receiver holds off, so the input backs up
    task automatic test_output_stall();
        wait_idle();
        calm = 1'b1;
        hold_req = 1'b1;
        repeat (24)
            send_item(CMD_MESH, voxel(int'($urandom_range(0, EDGE - 1)),
                                      int'($urandom_range(0, HEIGHT - 1)),
                                      int'($urandom_range(0, EDGE - 1)),
                                      1'b1, 24'($urandom())));
        calm = 1'b0;
    endtask

    task automatic mesh_cluster();
        int cx, cy, cz, k, dx, dy, dz, shade;
        cx = int'($urandom_range(0, RING - 1)) - 1;
        cz = int'($urandom_range(0, RING - 1)) - 1;
        if ($urandom_range(0, 7) == 0)
            cy = ($urandom_range(0, 1) != 0) ? HEIGHT - 1 : 0;
        else
            cy = int'($urandom_range(0, HEIGHT - 1));
        repeat ($urandom_range(0, 7)) begin
            // an index of FACES lands on the voxel itself
            face_geometry(STEP_W'($urandom_range(0, FACES)), dx, dy, dz, shade);
            send_item(CMD_LOAD, voxel(cx + dx, cy + dy, cz + dz,
                                      $urandom_range(0, 3) != 0, 24'($urandom())));
        end
        send_item(CMD_MESH, voxel(cx, cy, cz, $urandom_range(0, 7) != 0, 24'($urandom())));
        if ($urandom_range(0, 2) == 0) begin
            k = int'($urandom_range(0, FACES - 1));
            face_geometry(STEP_W'(k), dx, dy, dz, shade);
            send_item(CMD_MESH, voxel(cx + dx, cy + dy, cz + dz, 1'b1, 24'($urandom())));
        end
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: send_item(CMD_UNUSED, random_fields());
            1: send_item(CMD_LOAD, random_fields());
            2: send_item(CMD_MESH, random_fields());
            default: send_item(CMD_MESH, voxel(int'($urandom_range(0, EDGE - 1)),
                                               int'($urandom_range(0, HEIGHT - 1)),
                                               int'($urandom_range(0, EDGE - 1)),
                                               1'b0, 24'($urandom())));
        endcase
    endtask

    task automatic test_random_meshing();
        int phase, start;
        for (phase = 0; phase < 4; phase++) begin
            wait_idle();
            if (phase == 0) begin
                write_reg(CFG_CHUNK_COL_X, '0);
                write_reg(CFG_CHUNK_COL_Z, '0);
            end else begin
                write_reg(CFG_CHUNK_COL_X, CFG_W'($urandom()));
                write_reg(CFG_CHUNK_COL_Z, CFG_W'($urandom()));
            end
            if (phase == 2)
                send_item(CMD_CLEAR, random_fields());
            start = applied_items;
            while (applied_items - start < RANDOM_ITEMS / 4) begin
                if ($urandom_range(0, 15) == 0)
                    calm = !calm;
                if ($urandom_range(0, 4) == 0)
                    send_noise();
                else
                    mesh_cluster();
            end
            calm = 1'b0;
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_faces();
        test_world_extremes();
        test_output_stall();
        test_random_meshing();
        wait_idle();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
